// File: sv/itp_pkg.sv
package itp_pkg;

	// field widths fixed by the trace record format
	localparam int ADDR_W  = 64;
	localparam int INDEX_W = 7;
	localparam int DIST_W  = 7;
	localparam int READ_W  = 48;
	localparam int FLAG_W  = 2;
	localparam int MEM_W   = 2;

	// branch distance histogram: one bin per bit length 2..65
	localparam int HIST_BINS = 64;
	localparam int HIST_AW   = 6;
	localparam int N_CLASSES = 5;

	// top bit positions where the extra-instruction counter steps up
	// (bit length 9 adds one, bit length 17 and over adds two)
	localparam logic [HIST_AW-1:0] EXTRA_ONE_TOP = HIST_AW'(7);
	localparam logic [HIST_AW-1:0] EXTRA_TWO_TOP = HIST_AW'(15);
	localparam logic [DIST_W-1:0]  DIST_BASE     = DIST_W'(2);
	localparam logic [DIST_W-1:0]  DIST_MAX      = DIST_W'(65);

	localparam logic ACT_RECORD = 1'b0;
	localparam logic ACT_READ   = 1'b1;

	localparam logic [FLAG_W-1:0] FLAG_UNUSED = 2'd0;
	localparam logic [FLAG_W-1:0] FLAG_READ   = 2'd1;
	localparam logic [FLAG_W-1:0] FLAG_WRITE  = 2'd2;

	localparam logic [MEM_W-1:0] MEM_LOAD  = 2'd1;
	localparam logic [MEM_W-1:0] MEM_STORE = 2'd2;

	typedef enum logic [2:0] {
		CLS_LOAD   = 3'd0,
		CLS_STORE  = 3'd1,
		CLS_UNCOND = 3'd2,
		CLS_COND   = 3'd3,
		CLS_OTHER  = 3'd4
	} cls_t;

	// which counter group a read item selects
	typedef enum logic [2:0] {
		RSEL_MICRO,
		RSEL_MACRO,
		RSEL_BIN,
		RSEL_CLASS,
		RSEL_FUSION,
		RSEL_WIDTH,
		RSEL_EXTRA,
		RSEL_NONE
	} rsel_t;

	typedef struct packed {
		logic               en;
		logic [HIST_AW-1:0] addr;
	} hist_port_t;

endpackage

// File: sv/itp_dist.sv
// Leading-one detect over the branch distance magnitude.
module itp_dist (
	input  logic [itp_pkg::ADDR_W-1:0]  mag,
	output logic [itp_pkg::HIST_AW-1:0] top
);

	always_comb begin
		top = '0;
		for (int i = 1; i < itp_pkg::ADDR_W; i++) begin
			if (mag[i]) begin
				top = itp_pkg::HIST_AW'(i);
			end
		end
	end

endmodule

// File: sv/itp_hist.sv
// Distance histogram store: one read port, one write port, registered read.
// Per-entry valid bits stand in for clearing; a write in the same cycle as
// a read of the same entry is forwarded.
module itp_hist #(
	parameter int CW = 48
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  itp_pkg::hist_port_t     rd,
	input  itp_pkg::hist_port_t     wr,
	input  logic [CW-1:0]           wr_data,
	output logic [CW-1:0]           rd_data
);

	logic [CW-1:0]                   mem [itp_pkg::HIST_BINS];
	logic [itp_pkg::HIST_BINS-1:0]   valid_q;
	logic [CW-1:0]                   rdata_q;
	logic [CW-1:0]                   fwd_data_q;
	logic                            rvalid_q;
	logic                            fwd_hit_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr_data;
		end
		if (rd.en) begin
			rdata_q    <= mem[rd.addr];
			fwd_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rvalid_q  <= 1'b0;
			fwd_hit_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd.en) begin
				rvalid_q  <= valid_q[rd.addr];
				fwd_hit_q <= wr.en && (wr.addr == rd.addr);
			end
		end
	end

	assign rd_data = fwd_hit_q ? fwd_data_q : (rvalid_q ? rdata_q : '0);

endmodule

// File: sv/instruction_trace_profiler.sv
// Instruction trace profiler. Takes one micro-op trace record (or a counter
// read) per cycle while trace_stall is low and returns one result item for
// each. The input register is followed by two pipeline stages and the
// result register. Stage 1 forms the absolute branch distance with two
// parallel subtractors; stage 2 finds its leading one, classes the op,
// tracks macro-op length and flag history, and issues the histogram read;
// stage 3 bumps the saturating counters and forms the result. Fixed
// counters live in flops; the 64-bin distance histogram is a one-read,
// one-write memory with write forwarding and per-entry valid bits, so it
// needs no clearing pass after reset. Throughput is one item per clock
// while result_stall is low; trace_stall rises only when all stages are full.
module instruction_trace_profiler #(
	parameter int COUNT_WIDTH = 48,
	parameter int MACRO_BINS  = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          trace_valid,
	output logic                          trace_stall,
	input  logic                          action,
	input  logic                          last_of_macro,
	input  logic [itp_pkg::ADDR_W-1:0]    instr_address,
	input  logic [itp_pkg::ADDR_W-1:0]    branch_target,
	input  logic [itp_pkg::FLAG_W-1:0]    flag_use,
	input  logic [itp_pkg::MEM_W-1:0]     mem_kind,
	input  logic [itp_pkg::INDEX_W-1:0]   counter_index,

	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [itp_pkg::READ_W-1:0]    read_value,
	output logic [2:0]                    op_class,
	output logic [itp_pkg::DIST_W-1:0]    distance_bits,
	output logic                          fused
);

	localparam int CW    = COUNT_WIDTH;
	localparam int BIN_W = $clog2(MACRO_BINS);
	localparam int OPS_W = $clog2(MACRO_BINS + 1);
	localparam int IW    = itp_pkg::INDEX_W;

	// counter index map
	localparam logic [IW-1:0] IDX_MICRO  = IW'(0);
	localparam logic [IW-1:0] IDX_MACRO  = IW'(1);
	localparam logic [IW-1:0] IDX_BIN    = IW'(2);
	localparam logic [IW-1:0] IDX_CLASS  = IW'(2 + MACRO_BINS);
	localparam logic [IW-1:0] IDX_FUSION = IW'(2 + MACRO_BINS + itp_pkg::N_CLASSES);
	localparam logic [IW-1:0] IDX_WIDTH  = IW'(3 + MACRO_BINS + itp_pkg::N_CLASSES);
	localparam logic [IW-1:0] IDX_EXTRA  = IW'(3 + MACRO_BINS + itp_pkg::N_CLASSES
		+ itp_pkg::HIST_BINS);

	function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] v, input logic [1:0] amt);
		logic [CW:0] sum;
		begin
			sum = {1'b0, v} + (CW+1)'(amt);
			return sum[CW] ? {CW{1'b1}} : sum[CW-1:0];
		end
	endfunction

	// ---------------- handshake ----------------
	logic v_s1, v_s2, v_s3;
	logic result_valid_q;
	logic rdy_out, rdy3, rdy2, rdy1;
	logic adv23, adv_out;

	assign rdy_out     = !result_valid_q || !result_stall;
	assign rdy3        = !v_s3 || rdy_out;
	assign rdy2        = !v_s2 || rdy3;
	assign rdy1        = !v_s1 || rdy2;
	assign trace_stall = !rdy1;
	assign adv23       = v_s2 && rdy3;
	assign adv_out     = v_s3 && rdy_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			v_s3           <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (rdy1)    v_s1           <= trace_valid;
			if (rdy2)    v_s2           <= v_s1;
			if (rdy3)    v_s3           <= v_s2;
			if (rdy_out) result_valid_q <= v_s3;
		end
	end

	// ---------------- stage 1: input register, distance magnitude ----------------
	logic                        action_s1, last_s1;
	logic [itp_pkg::ADDR_W-1:0]  addr_s1, target_s1;
	logic [itp_pkg::FLAG_W-1:0]  flags_s1;
	logic [itp_pkg::MEM_W-1:0]   mem_s1;
	logic [IW-1:0]               index_s1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			action_s1 <= action;
			last_s1   <= last_of_macro;
			addr_s1   <= instr_address;
			target_s1 <= branch_target;
			flags_s1  <= flag_use;
			mem_s1    <= mem_kind;
			index_s1  <= counter_index;
		end
	end

	logic [itp_pkg::ADDR_W-1:0] diff_fwd, diff_bwd, mag_s1;

	assign diff_fwd = target_s1 - addr_s1;
	assign diff_bwd = addr_s1 - target_s1;
	assign mag_s1   = diff_fwd[itp_pkg::ADDR_W-1] ? diff_bwd : diff_fwd;

	// ---------------- stage 2: bit length, class, macro/flag state ----------------
	logic                        read_s2, last_s2, branch_s2;
	logic [itp_pkg::ADDR_W-1:0]  mag_s2;
	logic [itp_pkg::FLAG_W-1:0]  flags_s2;
	logic [itp_pkg::MEM_W-1:0]   mem_s2;
	logic [IW-1:0]               index_s2;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			read_s2   <= (action_s1 == itp_pkg::ACT_READ);
			last_s2   <= last_s1;
			branch_s2 <= |target_s1;
			mag_s2    <= mag_s1;
			flags_s2  <= flags_s1;
			mem_s2    <= mem_s1;
			index_s2  <= index_s1;
		end
	end

	logic [itp_pkg::HIST_AW-1:0] top_s2;

	itp_dist u_dist (
		.mag (mag_s2),
		.top (top_s2)
	);

	logic [OPS_W-1:0]           ops_q, ops_next;
	logic [itp_pkg::FLAG_W-1:0] prev_flags_q;
	itp_pkg::cls_t              cls_rec, cls_sel;
	logic                       fused_rec;
	logic [BIN_W-1:0]           bin_sel;
	itp_pkg::rsel_t             rsel;
	logic [itp_pkg::HIST_AW-1:0] hist_raddr;

	assign ops_next = (ops_q < OPS_W'(MACRO_BINS)) ? ops_q + OPS_W'(1) : ops_q;

	always_comb begin
		fused_rec = 1'b0;
		priority if (mem_s2 == itp_pkg::MEM_LOAD) begin
			cls_rec = itp_pkg::CLS_LOAD;
		end else if (mem_s2 == itp_pkg::MEM_STORE) begin
			cls_rec = itp_pkg::CLS_STORE;
		end else if (branch_s2 && flags_s2 == itp_pkg::FLAG_UNUSED) begin
			cls_rec = itp_pkg::CLS_UNCOND;
		end else if (branch_s2 && flags_s2 == itp_pkg::FLAG_READ) begin
			cls_rec   = itp_pkg::CLS_COND;
			fused_rec = (prev_flags_q == itp_pkg::FLAG_WRITE);
		end else begin
			cls_rec = itp_pkg::CLS_OTHER;
		end
	end

	// read decode: pick the group, and reuse the bin/class/address fields
	always_comb begin
		rsel       = itp_pkg::RSEL_NONE;
		bin_sel    = BIN_W'(ops_next - OPS_W'(1));
		cls_sel    = cls_rec;
		hist_raddr = top_s2;
		if (read_s2) begin
			priority if (index_s2 == IDX_MICRO) begin
				rsel = itp_pkg::RSEL_MICRO;
			end else if (index_s2 == IDX_MACRO) begin
				rsel = itp_pkg::RSEL_MACRO;
			end else if (index_s2 < IDX_CLASS) begin
				rsel    = itp_pkg::RSEL_BIN;
				bin_sel = BIN_W'(index_s2 - IDX_BIN);
			end else if (index_s2 < IDX_FUSION) begin
				rsel    = itp_pkg::RSEL_CLASS;
				cls_sel = itp_pkg::cls_t'(3'(index_s2 - IDX_CLASS));
			end else if (index_s2 == IDX_FUSION) begin
				rsel = itp_pkg::RSEL_FUSION;
			end else if (index_s2 < IDX_EXTRA) begin
				rsel       = itp_pkg::RSEL_WIDTH;
				hist_raddr = itp_pkg::HIST_AW'(index_s2 - IDX_WIDTH);
			end else if (index_s2 == IDX_EXTRA) begin
				rsel = itp_pkg::RSEL_EXTRA;
			end else begin
				rsel = itp_pkg::RSEL_NONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ops_q        <= '0;
			prev_flags_q <= itp_pkg::FLAG_UNUSED;
		end else if (adv23 && !read_s2) begin
			ops_q        <= last_s2 ? '0 : ops_next;
			prev_flags_q <= flags_s2;
		end
	end

	// ---------------- stage 3: counter update and result ----------------
	logic                        read_s3, last_s3, branch_s3, fused_s3;
	logic [itp_pkg::HIST_AW-1:0] top_s3;
	itp_pkg::cls_t               cls_s3;
	logic [BIN_W-1:0]            bin_s3;
	itp_pkg::rsel_t              rsel_s3;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			read_s3   <= read_s2;
			last_s3   <= last_s2;
			branch_s3 <= branch_s2;
			fused_s3  <= fused_rec;
			top_s3    <= top_s2;
			cls_s3    <= cls_sel;
			bin_s3    <= bin_sel;
			rsel_s3   <= rsel;
		end
	end

	itp_pkg::hist_port_t hist_rd, hist_wr;
	logic [CW-1:0]       hist_val;

	assign hist_rd.en   = adv23;
	assign hist_rd.addr = hist_raddr;
	assign hist_wr.en   = adv_out && !read_s3 && branch_s3;
	assign hist_wr.addr = top_s3;

	itp_hist #(
		.CW (CW)
	) u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd      (hist_rd),
		.wr      (hist_wr),
		.wr_data (sat_add(hist_val, 2'd1)),
		.rd_data (hist_val)
	);

	logic [CW-1:0] micro_q, macro_q, fusion_q, extra_q;
	logic [CW-1:0] bin_q [MACRO_BINS];
	logic [CW-1:0] cls_cnt_q [itp_pkg::N_CLASSES];
	logic [1:0]    extra_amt;

	assign extra_amt = (top_s3 >= itp_pkg::EXTRA_TWO_TOP) ? 2'd2 :
	                   (top_s3 >= itp_pkg::EXTRA_ONE_TOP) ? 2'd1 : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			micro_q  <= '0;
			macro_q  <= '0;
			fusion_q <= '0;
			extra_q  <= '0;
			for (int i = 0; i < MACRO_BINS; i++) bin_q[i] <= '0;
			for (int i = 0; i < itp_pkg::N_CLASSES; i++) cls_cnt_q[i] <= '0;
		end else if (adv_out && !read_s3) begin
			micro_q <= sat_add(micro_q, 2'd1);
			if (last_s3) begin
				macro_q <= sat_add(macro_q, 2'd1);
				for (int i = 0; i < MACRO_BINS; i++) begin
					if (bin_s3 == BIN_W'(i)) bin_q[i] <= sat_add(bin_q[i], 2'd1);
				end
			end
			cls_cnt_q[cls_s3] <= sat_add(cls_cnt_q[cls_s3], 2'd1);
			if (fused_s3) fusion_q <= sat_add(fusion_q, 2'd1);
			if (branch_s3) extra_q <= sat_add(extra_q, extra_amt);
		end
	end

	logic [CW-1:0]               cnt_val;
	logic [itp_pkg::ADDR_W-1:0]  cnt_wide;
	logic [itp_pkg::READ_W-1:0]  read_clip;

	always_comb begin
		unique case (rsel_s3)
			itp_pkg::RSEL_MICRO:  cnt_val = micro_q;
			itp_pkg::RSEL_MACRO:  cnt_val = macro_q;
			itp_pkg::RSEL_BIN:    cnt_val = bin_q[bin_s3];
			itp_pkg::RSEL_CLASS:  cnt_val = cls_cnt_q[cls_s3];
			itp_pkg::RSEL_FUSION: cnt_val = fusion_q;
			itp_pkg::RSEL_WIDTH:  cnt_val = hist_val;
			itp_pkg::RSEL_EXTRA:  cnt_val = extra_q;
			itp_pkg::RSEL_NONE:   cnt_val = '0;
			default:              cnt_val = '0;
		endcase
	end

	// clip wide counters to the 48-bit read port
	assign cnt_wide  = itp_pkg::ADDR_W'(cnt_val);
	assign read_clip = (|cnt_wide[itp_pkg::ADDR_W-1:itp_pkg::READ_W]) ?
	                   {itp_pkg::READ_W{1'b1}} : cnt_wide[itp_pkg::READ_W-1:0];

	// ---------------- result register ----------------
	logic [itp_pkg::READ_W-1:0] read_value_q;
	logic [2:0]                 op_class_q;
	logic [itp_pkg::DIST_W-1:0] distance_bits_q;
	logic                       fused_q;
	logic                       is_read_q;

	always_ff @(posedge clk) begin
		if (adv_out) begin
			is_read_q <= read_s3;
			if (read_s3) begin
				read_value_q    <= read_clip;
				op_class_q      <= '0;
				distance_bits_q <= '0;
				fused_q         <= 1'b0;
			end else begin
				read_value_q    <= '0;
				op_class_q      <= cls_s3;
				distance_bits_q <= branch_s3 ?
					itp_pkg::DIST_W'(top_s3) + itp_pkg::DIST_BASE : '0;
				fused_q         <= fused_s3;
			end
		end
	end

	assign result_valid  = result_valid_q;
	assign read_value    = read_value_q;
	assign op_class      = op_class_q;
	assign distance_bits = distance_bits_q;
	assign fused         = fused_q;

	// ---------------- assertions ----------------
	a_read_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && is_read_q |->
			op_class_q == 3'(itp_pkg::CLS_LOAD) && distance_bits_q == '0 && !fused_q)
		else $error("read item carries record fields");

	a_fused_is_cond: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && fused_q |-> op_class_q == 3'(itp_pkg::CLS_COND))
		else $error("fusion pair not classed conditional");

	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> distance_bits_q != itp_pkg::DIST_W'(1)
			&& distance_bits_q <= itp_pkg::DIST_MAX)
		else $error("distance bit length out of range");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		trace_stall |-> v_s1 && v_s2 && v_s3 && result_valid_q)
		else $error("input stalled with a free stage");

endmodule

// File: bench/tb_top.sv
module tb_top;

	// The bench runs the profiler with 16-bit counters rather than the default.
	localparam int CNT_W      = 16;
	localparam int MACRO_LEN  = 5;

	// counter bank layout
	localparam int IDX_MICRO     = 0;
	localparam int IDX_MACRO     = 1;
	localparam int IDX_PER_MACRO = 2;
	localparam int IDX_CLASS     = IDX_PER_MACRO + MACRO_LEN;
	localparam int IDX_FUSION    = IDX_CLASS + itp_pkg::N_CLASSES;
	localparam int IDX_WIDTH     = IDX_FUSION + 1;
	localparam int IDX_EXTRA     = IDX_WIDTH + itp_pkg::HIST_BINS;
	localparam int N_COUNTERS    = IDX_EXTRA + 1;

	localparam logic [63:0] COUNT_MAX = {64{1'b1}} >> (64 - CNT_W);
	localparam logic [63:0] READ_MAX  = (64'd1 << itp_pkg::READ_W) - 64'd1;

	// run length control
	localparam int RANDOM_ITEMS = 600;
	localparam int DRAIN_CYCLES = 16;
	localparam int RUN_LIMIT    = 1_500_000;

	typedef struct {
		logic                         act;
		logic                         last;
		logic [itp_pkg::ADDR_W-1:0]   addr;
		logic [itp_pkg::ADDR_W-1:0]   target;
		logic [itp_pkg::FLAG_W-1:0]   flags;
		logic [itp_pkg::MEM_W-1:0]    mem;
		logic [itp_pkg::INDEX_W-1:0]  idx;
	} trace_rec_t;

	typedef struct {
		logic [itp_pkg::READ_W-1:0]   value;
		logic [2:0]                   cls;
		logic [itp_pkg::DIST_W-1:0]   dbits;
		logic                         fused;
	} profile_res_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// block inputs, all known from time zero
	logic                         trace_valid   = 1'b0;
	logic                         action        = itp_pkg::ACT_RECORD;
	logic                         last_of_macro = 1'b0;
	logic [itp_pkg::ADDR_W-1:0]   instr_address = '0;
	logic [itp_pkg::ADDR_W-1:0]   branch_target = '0;
	logic [itp_pkg::FLAG_W-1:0]   flag_use      = itp_pkg::FLAG_UNUSED;
	logic [itp_pkg::MEM_W-1:0]    mem_kind      = '0;
	logic [itp_pkg::INDEX_W-1:0]  counter_index = '0;
	logic                         result_stall  = 1'b0;

	// block outputs
	logic                         trace_stall;
	logic                         result_valid;
	logic [itp_pkg::READ_W-1:0]   read_value;
	logic [2:0]                   op_class;
	logic [itp_pkg::DIST_W-1:0]   distance_bits;
	logic                         fused;

	// items waiting to be sent, and results the profiler owes us
	trace_rec_t   pending_recs[$];
	profile_res_t expected_results[$];

	// shadow of the profiler state
	logic [63:0]                count_bank[N_COUNTERS];
	int                         macro_len;
	logic [itp_pkg::FLAG_W-1:0] last_flags;

	int error_count = 0;
	int cycle_cnt = 0;

	instruction_trace_profiler #(
		.COUNT_WIDTH(CNT_W),
		.MACRO_BINS(MACRO_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.trace_valid(trace_valid),
		.trace_stall(trace_stall),
		.action(action),
		.last_of_macro(last_of_macro),
		.instr_address(instr_address),
		.branch_target(branch_target),
		.flag_use(flag_use),
		.mem_kind(mem_kind),
		.counter_index(counter_index),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.read_value(read_value),
		.op_class(op_class),
		.distance_bits(distance_bits),
		.fused(fused)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------

	// saturating add into one shadow counter
	task automatic count_up(input int idx, input logic [63:0] amount);
		if (amount > COUNT_MAX - count_bank[idx])
			count_bank[idx] = COUNT_MAX;
		else
			count_bank[idx] = count_bank[idx] + amount;
	endtask

	function automatic int msb_pos(input logic [63:0] v);
		int pos;
		pos = 0;
		for (int i = 0; i < 64; i++)
			if (v[i])
				pos = i;
		return pos;
	endfunction

	// Apply one accepted item to the shadow state and queue its result.
	task automatic profile_record(input trace_rec_t r);
		profile_res_t  res;
		logic [63:0]   diff;
		logic [63:0]   value;
		int            bits;
		itp_pkg::cls_t cls;
		res.value = '0;
		res.cls   = '0;
		res.dbits = '0;
		res.fused = 1'b0;
		if (r.act == itp_pkg::ACT_READ) begin
			// reads leave state alone; unknown indexes read as zero
			value = (int'(r.idx) < N_COUNTERS) ? count_bank[r.idx] : 64'd0;
			if (value > READ_MAX)
				value = READ_MAX;
			res.value = value[itp_pkg::READ_W-1:0];
			expected_results.push_back(res);
			return;
		end

		count_up(IDX_MICRO, 64'd1);
		// macro-op length sticks at the last bin
		if (macro_len < MACRO_LEN)
			macro_len++;
		if (r.last) begin
			count_up(IDX_MACRO, 64'd1);
			count_up(IDX_PER_MACRO + macro_len - 1, 64'd1);
			macro_len = 0;
		end

		// taken branch: bit length of |target - address|, with a zero
		// distance counted as length 2 and -2^63 landing at 65
		bits = 0;
		if (r.target != '0) begin
			diff = r.target - r.addr;
			if (diff[63])
				diff = ~diff + 64'd1;
			bits = (diff == '0) ? 2 : 2 + msb_pos(diff);
			count_up(IDX_WIDTH + bits - 2, 64'd1);
			if (bits >= 9 && bits <= 16)
				count_up(IDX_EXTRA, 64'd1);
			else if (bits >= 17)
				count_up(IDX_EXTRA, 64'd2);
		end

		// memory kind three falls through as no access; flag use three
		// makes a branch neither conditional nor unconditional
		if (r.mem == itp_pkg::MEM_LOAD)
			cls = itp_pkg::CLS_LOAD;
		else if (r.mem == itp_pkg::MEM_STORE)
			cls = itp_pkg::CLS_STORE;
		else if (r.target != '0 && r.flags == itp_pkg::FLAG_UNUSED)
			cls = itp_pkg::CLS_UNCOND;
		else if (r.target != '0 && r.flags == itp_pkg::FLAG_READ) begin
			cls = itp_pkg::CLS_COND;
			if (last_flags == itp_pkg::FLAG_WRITE) begin
				res.fused = 1'b1;
				count_up(IDX_FUSION, 64'd1);
			end
		end else
			cls = itp_pkg::CLS_OTHER;
		count_up(IDX_CLASS + int'(cls), 64'd1);
		last_flags = r.flags;

		res.cls   = cls;
		res.dbits = itp_pkg::DIST_W'(bits);
		expected_results.push_back(res);
	endtask

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------

	task automatic queue_op(input logic act, input logic last,
			input logic [63:0] addr, input logic [63:0] target,
			input logic [itp_pkg::FLAG_W-1:0] flags, input logic [itp_pkg::MEM_W-1:0] mem,
			input int idx);
		trace_rec_t r;
		r.act    = act;
		r.last   = last;
		r.addr   = addr;
		r.target = target;
		r.flags  = flags;
		r.mem    = mem;
		r.idx    = itp_pkg::INDEX_W'(idx);
		pending_recs.push_back(r);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [itp_pkg::FLAG_W-1:0] rand_flags();
		return itp_pkg::FLAG_W'($urandom_range(0, 3));
	endfunction

	function automatic logic [itp_pkg::MEM_W-1:0] rand_mem();
		return itp_pkg::MEM_W'($urandom_range(0, 3));
	endfunction

	function automatic logic rand_bit();
		return 1'($urandom_range(0, 1));
	endfunction

	// branch target at a random distance length from addr, either direction
	function automatic logic [63:0] rand_target(input logic [63:0] addr);
		logic [63:0] span;
		int          len;
		len = $urandom_range(0, 64);
		span = '0;
		if (len != 0) begin
			span = rand64() >> (64 - len);
			span[len-1] = 1'b1;
		end
		return $urandom_range(0, 1) ? addr + span : addr - span;
	endfunction

	task automatic queue_read();
		int idx;
		// mostly real counters, some indexes past the end of the bank
		idx = ($urandom_range(0, 4) != 0) ? $urandom_range(0, N_COUNTERS - 1)
			: $urandom_range(N_COUNTERS, 127);
		queue_op(itp_pkg::ACT_READ, rand_bit(), rand64(), rand64(),
			rand_flags(), rand_mem(), idx);
	endtask

	task automatic queue_micro_op(input logic last);
		logic [63:0] addr;
		logic [63:0] target;
		addr = rand64();
		case ($urandom_range(0, 3))
			0, 1: target = '0;
			2: target = rand_target(addr);
			default: target = rand64();
		endcase
		queue_op(itp_pkg::ACT_RECORD, last, addr, target, rand_flags(),
			rand_mem(), $urandom_range(0, 127));
	endtask

	// flag writer (at times a store) then a conditional branch of mem kind none or three
	task automatic queue_fusion_pair();
		logic [63:0] addr;
		addr = rand64();
		queue_op(itp_pkg::ACT_RECORD, 1'b0, addr,
			$urandom_range(0, 1) ? rand_target(addr) : '0,
			itp_pkg::FLAG_WRITE, $urandom_range(0, 4) == 0 ? itp_pkg::MEM_STORE : 2'd0,
			$urandom_range(0, 127));
		addr = rand64();
		queue_op(itp_pkg::ACT_RECORD, rand_bit(), addr, rand_target(addr) | 64'd1,
			itp_pkg::FLAG_READ, $urandom_range(0, 1) ? 2'd3 : 2'd0,
			$urandom_range(0, 127));
	endtask

	task automatic queue_random_part(input int count);
		int stop;
		int len;
		stop = pending_recs.size() + count;
		while (pending_recs.size() < stop) begin
			case ($urandom_range(0, 9))
				0, 1, 2: queue_read();
				3, 4: queue_fusion_pair();
				9: begin
					// noise: a record with every field random
					queue_op(itp_pkg::ACT_RECORD, rand_bit(), rand64(), rand64(),
						rand_flags(), rand_mem(), $urandom_range(0, 127));
				end
				default: begin
					// one macro-op of 1..8 micro-ops, last flag on the final one
					len = $urandom_range(1, 8);
					for (int i = 1; i <= len; i++)
						queue_micro_op(i == len);
				end
			endcase
		end
	endtask

	// ---------------------------------------------------------------
	// Driver: bursts of items with random gaps between them
	// ---------------------------------------------------------------
	trace_rec_t cur_rec;
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trace_valid <= 1'b0;
			burst_left  <= 0;
			gap_left    <= 0;
		end else begin
			if (trace_valid && !trace_stall)
				profile_record(cur_rec);
			// a stalled item holds; otherwise move on to the next one
			if (!trace_valid || !trace_stall) begin
				if (gap_left != 0) begin
					gap_left    <= gap_left - 1;
					trace_valid <= 1'b0;
				end else if (pending_recs.size() != 0) begin
					cur_rec = pending_recs.pop_front();
					action        <= cur_rec.act;
					last_of_macro <= cur_rec.last;
					instr_address <= cur_rec.addr;
					branch_target <= cur_rec.target;
					flag_use      <= cur_rec.flags;
					mem_kind      <= cur_rec.mem;
					counter_index <= cur_rec.idx;
					trace_valid   <= 1'b1;
					if (burst_left <= 1) begin
						// now and then a long unbroken stretch
						burst_left <= ($urandom_range(0, 7) == 0) ? 200
							: $urandom_range(1, 16);
						gap_left   <= $urandom_range(0, 5);
					end else
						burst_left <= burst_left - 1;
				end else
					trace_valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Monitor: result checking plus the receiver's stall pattern
	// ---------------------------------------------------------------
	stall_mode_t stall_mode = STALL_NONE;
	logic [4:0]  stall_phase = '0;

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		profile_res_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_phase  <= '0;
			stall_mode   <= STALL_NONE;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual value %0h class %0d",
						$time, read_value, op_class);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("read_value", 64'(want.value), 64'(read_value));
					check_field("op_class", 64'(want.cls), 64'(op_class));
					check_field("distance_bits", 64'(want.dbits), 64'(distance_bits));
					check_field("fused", 64'(want.fused), 64'(fused));
				end
			end
			// new stall behavior each time the 5-bit stall phase wraps to zero
			stall_phase <= stall_phase + 1'b1;
			if (stall_phase == '0)
				stall_mode <= stall_mode_t'($urandom_range(0, 3));
			case (stall_mode)
				STALL_NONE:  result_stall <= 1'b0;
				STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: result_stall <= rand_bit();
				default:     result_stall <= (stall_phase[2:0] < 3'd3);
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Sequence and end of run
	// ---------------------------------------------------------------
	initial begin
		for (int i = 0; i < N_COUNTERS; i++)
			count_bank[i] = '0;
		macro_len  = 0;
		last_flags = itp_pkg::FLAG_UNUSED;

		// directed: field extremes, classes, distances and corner cases
		queue_op(itp_pkg::ACT_READ, 1'b1, '1, '1, 2'd3, 2'd3, IDX_MICRO);
		queue_op(itp_pkg::ACT_RECORD, 1'b0, 64'h1000, '0, itp_pkg::FLAG_UNUSED,
			itp_pkg::MEM_LOAD, 0);
		queue_op(itp_pkg::ACT_RECORD, 1'b0, 64'h1004, '0, itp_pkg::FLAG_READ,
			itp_pkg::MEM_STORE, 0);
		// branch to itself, all-ones address
		queue_op(itp_pkg::ACT_RECORD, 1'b0, '1, '1, itp_pkg::FLAG_UNUSED, 2'd0, 127);
		queue_op(itp_pkg::ACT_RECORD, 1'b0, 64'h2000, '0, itp_pkg::FLAG_WRITE, 2'd0, 0);
		// fused conditional branch, length 9
		queue_op(itp_pkg::ACT_RECORD, 1'b0, 64'h2004, 64'h2084, itp_pkg::FLAG_READ, 2'd0, 0);
		// backward length 16, not fused after a conditional
		queue_op(itp_pkg::ACT_RECORD, 1'b0, 64'h7000, 64'h3000, itp_pkg::FLAG_READ, 2'd0, 0);
		// length 8 with mem kind three; closes a macro-op of seven
		queue_op(itp_pkg::ACT_RECORD, 1'b1, 64'h100, 64'h17F, itp_pkg::FLAG_UNUSED, 2'd3, 0);
		// length 17, one-op macro
		queue_op(itp_pkg::ACT_RECORD, 1'b1, 64'h0, 64'h8000, itp_pkg::FLAG_UNUSED, 2'd0, 0);
		// difference of -2^63 and +2^63
		queue_op(itp_pkg::ACT_RECORD, 1'b0, 64'h8000_0000_0000_0001, 64'h1,
			itp_pkg::FLAG_UNUSED, 2'd0, 0);
		queue_op(itp_pkg::ACT_RECORD, 1'b0, 64'h0, 64'h8000_0000_0000_0000,
			itp_pkg::FLAG_UNUSED, 2'd0, 0);
		queue_op(itp_pkg::ACT_RECORD, 1'b0, 64'h0, '1, itp_pkg::FLAG_UNUSED, 2'd0, 0);
		// flag use three on a branch, then a conditional that must not fuse
		queue_op(itp_pkg::ACT_RECORD, 1'b0, 64'h4000, 64'h4010, 2'd3, 2'd0, 0);
		queue_op(itp_pkg::ACT_RECORD, 1'b0, 64'h4010, 64'h4000, itp_pkg::FLAG_READ, 2'd0, 0);
		// flag-writing store, then a conditional load: classed load
		queue_op(itp_pkg::ACT_RECORD, 1'b0, 64'h5000, '0, itp_pkg::FLAG_WRITE,
			itp_pkg::MEM_STORE, 0);
		queue_op(itp_pkg::ACT_RECORD, 1'b0, 64'h5004, 64'h5100, itp_pkg::FLAG_READ,
			itp_pkg::MEM_LOAD, 0);
		queue_op(itp_pkg::ACT_RECORD, 1'b0, 64'h6000, '0, itp_pkg::FLAG_WRITE, 2'd0, 0);
		queue_op(itp_pkg::ACT_RECORD, 1'b1, 64'h6004, 64'h5000, itp_pkg::FLAG_READ, 2'd3, 0);
		queue_op(itp_pkg::ACT_READ, 1'b0, '0, '0, itp_pkg::FLAG_UNUSED, 2'd0, IDX_MACRO);
		queue_op(itp_pkg::ACT_READ, 1'b0, '0, '0, itp_pkg::FLAG_UNUSED, 2'd0, IDX_PER_MACRO);
		queue_op(itp_pkg::ACT_READ, 1'b0, '0, '0, itp_pkg::FLAG_UNUSED, 2'd0, IDX_CLASS - 1);
		queue_op(itp_pkg::ACT_READ, 1'b0, '0, '0, itp_pkg::FLAG_UNUSED, 2'd0,
			IDX_CLASS + int'(itp_pkg::CLS_COND));
		queue_op(itp_pkg::ACT_READ, 1'b0, '0, '0, itp_pkg::FLAG_UNUSED, 2'd0, IDX_FUSION);
		queue_op(itp_pkg::ACT_READ, 1'b0, '0, '0, itp_pkg::FLAG_UNUSED, 2'd0, IDX_EXTRA - 1);
		queue_op(itp_pkg::ACT_READ, 1'b0, '0, '0, itp_pkg::FLAG_UNUSED, 2'd0, IDX_EXTRA);
		queue_op(itp_pkg::ACT_READ, 1'b0, '0, '0, itp_pkg::FLAG_UNUSED, 2'd0, N_COUNTERS);

		queue_random_part(RANDOM_ITEMS / 2);
		queue_random_part(RANDOM_ITEMS / 2);

		// sweep the whole index range at the end
		for (int i = 0; i < 128; i++)
			queue_op(itp_pkg::ACT_READ, 1'b0, '0, '0, itp_pkg::FLAG_UNUSED, 2'd0, i);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_recs.size() != 0 || trace_valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		// catch any stray result after the last expected one
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// watchdog
	initial begin
		wait (cycle_cnt >= RUN_LIMIT);
		$display("%0t: timeout with %0d results outstanding", $time,
			expected_results.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: files.f
sv/itp_pkg.sv
sv/itp_dist.sv
sv/itp_hist.sv
sv/instruction_trace_profiler.sv
bench/tb_top.sv
